@@ rtl/mcbc_pkg.sv @@
package mcbc_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int START_W = 32;
    localparam int LEN_W = 3;
    localparam int STAT_W = 2;
    localparam int FIFO_DEPTH = 2;

    localparam logic [3:0] ENC_MONO     = 4'd0;
    localparam logic [3:0] ENC_BIG5     = 4'd1;
    localparam logic [3:0] ENC_EUC_CN   = 4'd2;
    localparam logic [3:0] ENC_EUC_JP   = 4'd3;
    localparam logic [3:0] ENC_EUC_JIS  = 4'd4;
    localparam logic [3:0] ENC_EUC_KR   = 4'd5;
    localparam logic [3:0] ENC_EUC_TW   = 4'd6;
    localparam logic [3:0] ENC_GB18030  = 4'd7;
    localparam logic [3:0] ENC_GBK      = 4'd8;
    localparam logic [3:0] ENC_JOHAB    = 4'd9;
    localparam logic [3:0] ENC_MULE     = 4'd10;
    localparam logic [3:0] ENC_SJIS     = 4'd11;
    localparam logic [3:0] ENC_SJIS2004 = 4'd12;
    localparam logic [3:0] ENC_UHC      = 4'd13;
    localparam logic [3:0] ENC_UTF8     = 4'd14;

    localparam logic [1:0] ST_VALID   = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    typedef enum logic [1:0] {
        V_MORE = 2'd0,
        V_DONE = 2'd1,
        V_BAD  = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [LEN_W-1:0]   char_length;
        logic [START_W-1:0] char_start;
    } res_t;

    function automatic logic rng(logic [7:0] x, logic [7:0] lo, logic [7:0] hi);
        return (x >= lo) && (x <= hi);
    endfunction

    // verdict for the first k bytes, given the first k-1 were a valid prefix
    function automatic verdict_t stage_f(logic [3:0] enc, logic [7:0] c, logic [7:0] b1,
                                         logic [7:0] x, logic [2:0] k);
        verdict_t v;
        logic [2:0] need;
        v = V_BAD;
        need = (c <= 8'hDF) ? 3'd2 : (c <= 8'hEF) ? 3'd3 : 3'd4;
        case (enc)
            ENC_BIG5: begin
                if (k == 3'd1) v = c < 8'h80 ? V_DONE : rng(c, 8'h81, 8'hFE) ? V_MORE : V_BAD;
                else if (k == 3'd2)
                    v = (rng(x, 8'h40, 8'h7E) || rng(x, 8'hA1, 8'hFE)) ? V_DONE : V_BAD;
            end
            ENC_EUC_CN, ENC_EUC_KR: begin
                if (k == 3'd1)
                    v = c < 8'h80 ? V_DONE
                      : rng(c, 8'hA1, (enc == ENC_EUC_CN) ? 8'hF7 : 8'hFE) ? V_MORE : V_BAD;
                else if (k == 3'd2) v = rng(x, 8'hA1, 8'hFE) ? V_DONE : V_BAD;
            end
            ENC_EUC_JP, ENC_EUC_JIS: begin
                if (k == 3'd1)
                    v = c < 8'h80 ? V_DONE
                      : (c == 8'h8E || c == 8'h8F || rng(c, 8'hA1, 8'hFE)) ? V_MORE : V_BAD;
                else if (k == 3'd2)
                    v = !rng(x, 8'hA1, 8'hFE) ? V_BAD : (c == 8'h8F) ? V_MORE : V_DONE;
                else if (k == 3'd3)
                    v = (c == 8'h8F && rng(x, 8'hA1, 8'hFE)) ? V_DONE : V_BAD;
            end
            ENC_EUC_TW: begin
                if (k == 3'd1)
                    v = c < 8'h80 ? V_DONE
                      : (c == 8'h8E || rng(c, 8'hA1, 8'hFE)) ? V_MORE : V_BAD;
                else if (k == 3'd2) begin
                    if (c == 8'h8E) v = rng(x, 8'hA1, 8'hB0) ? V_MORE : V_BAD;
                    else v = rng(x, 8'hA1, 8'hFE) ? V_DONE : V_BAD;
                end else if (k == 3'd3)
                    v = (c == 8'h8E && rng(x, 8'hA1, 8'hFE)) ? V_MORE : V_BAD;
                else if (k == 3'd4)
                    v = (c == 8'h8E && rng(x, 8'hA1, 8'hFE)) ? V_DONE : V_BAD;
            end
            ENC_GB18030: begin
                if (k == 3'd1) v = (c <= 8'h80 || c == 8'hFF) ? V_DONE : V_MORE;
                else if (k == 3'd2) begin
                    if (rng(x, 8'h40, 8'hFE)) v = (x == 8'h7F) ? V_BAD : V_DONE;
                    else v = rng(x, 8'h30, 8'h39) ? V_MORE : V_BAD;
                end else if (k == 3'd3)
                    v = (rng(b1, 8'h30, 8'h39) && rng(x, 8'h81, 8'hFE)) ? V_MORE : V_BAD;
                else if (k == 3'd4)
                    v = (rng(b1, 8'h30, 8'h39) && rng(x, 8'h30, 8'h39)) ? V_DONE : V_BAD;
            end
            ENC_GBK: begin
                if (k == 3'd1) v = c < 8'h80 ? V_DONE : rng(c, 8'h81, 8'hFE) ? V_MORE : V_BAD;
                else if (k == 3'd2) v = (rng(x, 8'h40, 8'hFE) && x != 8'h7F) ? V_DONE : V_BAD;
            end
            ENC_JOHAB: begin
                if (k == 3'd1) begin
                    if (c < 8'h80) v = V_DONE;
                    else v = (rng(c, 8'h84, 8'hD3) || rng(c, 8'hD8, 8'hDE)
                              || rng(c, 8'hE0, 8'hF9)) ? V_MORE : V_BAD;
                end else if (k == 3'd2) begin
                    if (rng(c, 8'h84, 8'hD3))
                        v = (rng(x, 8'h41, 8'h7E) || rng(x, 8'h81, 8'hFE)) ? V_DONE : V_BAD;
                    else
                        v = (rng(x, 8'h31, 8'h7E) || rng(x, 8'h91, 8'hFE)) ? V_DONE : V_BAD;
                end
            end
            ENC_MULE: begin
                if (k == 3'd1)
                    v = c < 8'h80 ? V_DONE
                      : (rng(c, 8'h81, 8'h8D) || rng(c, 8'h90, 8'h9D)) ? V_MORE : V_BAD;
                else if (k == 3'd2) begin
                    if (rng(c, 8'h81, 8'h8D)) v = x >= 8'hA0 ? V_DONE : V_BAD;
                    else if (rng(c, 8'h90, 8'h99)) v = x >= 8'hA0 ? V_MORE : V_BAD;
                    else if (c == 8'h9A) v = rng(x, 8'hA0, 8'hDF) ? V_MORE : V_BAD;
                    else if (c == 8'h9B) v = rng(x, 8'hE0, 8'hEF) ? V_MORE : V_BAD;
                    else if (c == 8'h9C) v = rng(x, 8'hF0, 8'hF4) ? V_MORE : V_BAD;
                    else if (c == 8'h9D) v = rng(x, 8'hF5, 8'hFE) ? V_MORE : V_BAD;
                end else if (k == 3'd3) begin
                    if (x < 8'hA0) v = V_BAD;
                    else if (rng(c, 8'h90, 8'h9B)) v = V_DONE;
                    else v = rng(c, 8'h9C, 8'h9D) ? V_MORE : V_BAD;
                end else if (k == 3'd4)
                    v = (rng(c, 8'h9C, 8'h9D) && x >= 8'hA0) ? V_DONE : V_BAD;
            end
            ENC_SJIS, ENC_SJIS2004: begin
                if (k == 3'd1) begin
                    if (c < 8'h80 || rng(c, 8'hA1, 8'hDF)) v = V_DONE;
                    else v = (rng(c, 8'h81, 8'h9F) || rng(c, 8'hE0, 8'hFC)) ? V_MORE : V_BAD;
                end else if (k == 3'd2)
                    v = (rng(x, 8'h40, 8'hFC) && x != 8'h7F) ? V_DONE : V_BAD;
            end
            ENC_UHC: begin
                if (k == 3'd1) v = c < 8'h80 ? V_DONE : (c != 8'hFF) ? V_MORE : V_BAD;
                else if (k == 3'd2) begin
                    if (c <= 8'hC6)
                        v = (rng(x, 8'h41, 8'h5A) || rng(x, 8'h61, 8'h7A)
                             || rng(x, 8'h80, 8'hFE)) ? V_DONE : V_BAD;
                    else v = rng(x, 8'hA1, 8'hFE) ? V_DONE : V_BAD;
                end
            end
            ENC_UTF8: begin
                if (k == 3'd1) v = c < 8'h80 ? V_DONE : rng(c, 8'hC0, 8'hF7) ? V_MORE : V_BAD;
                else if (!rng(x, 8'h80, 8'hBF) || k > need) v = V_BAD;
                else v = (k == need) ? V_DONE : V_MORE;
            end
            default: begin
                v = (k == 3'd1) ? V_DONE : V_BAD;
            end
        endcase
        return v;
    endfunction

endpackage

@@ rtl/mcbc_front.sv @@
module mcbc_front #(
    parameter int OFFSET_BITS = mcbc_pkg::OFFSET_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  logic [3:0]          enc,
    output logic                push,
    output mcbc_pkg::res_t      push_res
);

    logic [7:0]             pend_reg [3];
    logic [1:0]             cnt_reg, cnt_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] orig_reg, orig_next;
    logic                   skip_reg, skip_next;

    logic [7:0]             seq [4];
    logic [2:0]             n;
    logic [OFFSET_BITS-1:0] origin;
    mcbc_pkg::verdict_t     v1, v2, v3, v4, vlast, verdict;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (i < 3 && 2'(i) < cnt_reg) seq[i] = pend_reg[i];
            else if (2'(i) == cnt_reg && i < 3) seq[i] = in_byte;
            else seq[i] = in_byte;
        end
    end

    assign n      = {1'b0, cnt_reg} + 3'd1;
    assign origin = (cnt_reg == 2'd0) ? pos_reg : orig_reg;

    // every held prefix is judged again under the current encoding
    assign v1 = mcbc_pkg::stage_f(enc, seq[0], seq[1], seq[0], 3'd1);
    assign v2 = mcbc_pkg::stage_f(enc, seq[0], seq[1], seq[1], 3'd2);
    assign v3 = mcbc_pkg::stage_f(enc, seq[0], seq[1], seq[2], 3'd3);
    assign v4 = mcbc_pkg::stage_f(enc, seq[0], seq[1], seq[3], 3'd4);

    always_comb begin
        case (cnt_reg)
            2'd0: vlast = v1;
            2'd1: vlast = (v1 == mcbc_pkg::V_MORE) ? v2 : mcbc_pkg::V_BAD;
            2'd2: vlast = (v1 == mcbc_pkg::V_MORE && v2 == mcbc_pkg::V_MORE)
                          ? v3 : mcbc_pkg::V_BAD;
            default: begin
                vlast = (v1 == mcbc_pkg::V_MORE && v2 == mcbc_pkg::V_MORE
                         && v3 == mcbc_pkg::V_MORE) ? v4 : mcbc_pkg::V_BAD;
            end
        endcase
        verdict = (vlast == mcbc_pkg::V_MORE && n == 3'd4) ? mcbc_pkg::V_BAD : vlast;
    end

    always_comb begin
        cnt_next  = cnt_reg;
        pos_next  = pos_reg;
        orig_next = orig_reg;
        skip_next = skip_reg;
        push      = 1'b0;
        push_res.char_start  = 32'(origin);
        push_res.char_length = n;
        push_res.status = (verdict == mcbc_pkg::V_DONE) ? mcbc_pkg::ST_VALID
                        : (verdict == mcbc_pkg::V_BAD) ? mcbc_pkg::ST_INVALID
                        : mcbc_pkg::ST_TRUNC;
        if (in_fire) begin
            pos_next = in_last ? '0 : pos_reg + 1'b1;
            if (skip_reg) begin
                if (in_last) begin
                    skip_next = 1'b0;
                    cnt_next  = 2'd0;
                end
            end else if (verdict == mcbc_pkg::V_MORE && !in_last) begin
                cnt_next  = n[1:0];
                orig_next = origin;
            end else begin
                push     = 1'b1;
                cnt_next = 2'd0;
                if (verdict == mcbc_pkg::V_BAD && !in_last) skip_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 2'd0;
            pos_reg  <= '0;
            orig_reg <= '0;
            skip_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            pos_reg  <= pos_next;
            orig_reg <= orig_next;
            skip_reg <= skip_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && !skip_reg && verdict == mcbc_pkg::V_MORE && !in_last
            && cnt_reg != 2'd3) begin
            pend_reg[cnt_reg] <= in_byte;
        end
    end

    a_skip_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        skip_reg |-> cnt_reg == 2'd0)
        else $error("held bytes while skipping");
    a_last_rewinds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_last) |=> pos_reg == '0)
        else $error("offset not restarted after last item");
    a_no_push_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && skip_reg) |-> !push)
        else $error("result while skipping");

endmodule

@@ rtl/mcbc_fifo.sv @@
module mcbc_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  mcbc_pkg::res_t push_res,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output mcbc_pkg::res_t head
);

    localparam int PW = (mcbc_pkg::FIFO_DEPTH > 1) ? $clog2(mcbc_pkg::FIFO_DEPTH) : 1;
    localparam int CW = $clog2(mcbc_pkg::FIFO_DEPTH + 1);

    mcbc_pkg::res_t mem_reg [mcbc_pkg::FIFO_DEPTH];
    logic [PW-1:0]  wp_reg, rp_reg;
    logic [CW-1:0]  cnt_reg;

    assign full      = cnt_reg == CW'(mcbc_pkg::FIFO_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign head      = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= (wp_reg == PW'(mcbc_pkg::FIFO_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)  rp_reg <= (rp_reg == PW'(mcbc_pkg::FIFO_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= push_res;
    end

endmodule

@@ rtl/mcbc_out.sv @@
module mcbc_out (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  mcbc_pkg::res_t q_head,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output mcbc_pkg::res_t m_res
);

    logic           vld_reg;
    mcbc_pkg::res_t res_reg;

    assign q_pop    = q_valid && (!vld_reg || m_tready);
    assign m_tvalid = vld_reg;
    assign m_res    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= 1'b0;
        else if (!vld_reg || m_tready) vld_reg <= q_valid;
    end

    always_ff @(posedge aclk) begin
        if (q_pop) res_reg <= q_head;
    end

endmodule

@@ rtl/multibyte_char_boundary_checker.sv @@
// output path: the result of the closing byte is registered in the queue, then in the output register
// throughput: one byte per cycle while the queue is not full; front classifier is combinational, a two-entry
// queue and the output register decouple it from m_tready
// reset: aresetn synchronous, active low; clears offsets, held count, skip flag,
// queue and encoding (single-byte)
module multibyte_char_boundary_checker #(
    parameter int OFFSET_BITS = mcbc_pkg::OFFSET_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // end_of_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // char_start[31:0], char_length[34:32], status[36:35]
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata  // encoding_select
);

    logic [3:0]     enc_reg;
    logic           fire, push, full, q_valid, q_pop;
    mcbc_pkg::res_t push_res, q_head, m_res;

    assign s_tready = !full;
    assign fire     = s_tvalid && s_tready;
    assign m_tdata  = {3'b000, m_res};

    always_ff @(posedge aclk) begin
        if (!aresetn) enc_reg <= mcbc_pkg::ENC_MONO;
        else if (cfg_we) enc_reg <= cfg_wdata;
    end

    mcbc_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .in_fire(fire), .in_byte(s_tdata),
        .in_last(s_tlast), .enc(enc_reg), .push(push), .push_res(push_res)
    );

    mcbc_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn), .push(push), .push_res(push_res), .full(full),
        .pop(q_pop), .not_empty(q_valid), .head(q_head)
    );

    mcbc_out u_out (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_res(m_res)
    );

endmodule
